// ===== src/mi_pkg.sv =====
package mi_pkg;

	localparam int LEN_W  = 24;
	localparam int ER_W   = 16;
	localparam int Z_W    = 20;
	localparam int NUM_W  = 34;
	localparam int DEN_W  = 32;
	localparam int K_W    = 6;
	localparam int MANT_W = 31;
	localparam int FRAC_W = 24;
	localparam int LG_W   = K_W + FRAC_W;
	localparam int LN_W   = 30;
	localparam int SQV_W  = 45;
	localparam int SQR_W  = 46;
	localparam int ROOT_W = 23;
	localparam int REM_W  = 44;
	localparam int QUO_W  = 23;
	localparam int ZM_W   = 22;

	// stage map
	localparam int ST_LZD   = 2;
	localparam int ST_NORM  = 3;
	localparam int ST_LG    = ST_NORM + FRAC_W + 1;
	localparam int ST_LN    = ST_LG + 1;
	localparam int ST_SQRT  = 1 + ROOT_W;
	localparam int ST_DIV0  = ST_SQRT + 1;
	localparam int ST_COEF  = ST_DIV0 + QUO_W;
	localparam int ST_Z     = ST_COEF + 1;
	localparam int DEPTH    = ST_Z + 1;

	localparam logic [9:0]        H_SCALE   = 10'd598;
	localparam logic [6:0]        W_SCALE   = 7'd80;
	localparam logic [6:0]        T_SCALE   = 7'd100;
	localparam logic [LN_W-1:0]   LN2_Q30   = 30'd744261118;
	localparam logic [16:0]       ER_OFFSET = 17'd5775;
	localparam logic [REM_W-1:0]  COEF_NUM  = 44'd87 << 36;
	localparam logic [ZM_W-1:0]   Z_POS_LIM = 22'd524287;
	localparam logic [ZM_W-1:0]   Z_NEG_LIM = 22'd524288;
	localparam logic signed [Z_W-1:0] Z_MAX = 20'sd524287;
	localparam logic signed [Z_W-1:0] Z_MIN = -20'sd524288;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_BAD_LOG  = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

endpackage

// ===== src/microstrip_impedance_unit.sv =====
// Microstrip impedance, fully pipelined.
// The sqrt and divider stages, one result bit per stage, set the depth.
// Throughput: one word per cycle; a stalled output freezes the whole pipe.
// Reset clears all stage valid bits; data registers are not reset.
module microstrip_impedance_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mi_pkg::LEN_W-1:0]          height,
	input  logic [mi_pkg::LEN_W-1:0]          width,
	input  logic [mi_pkg::LEN_W-1:0]          thickness,
	input  logic [mi_pkg::ER_W-1:0]           permittivity,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mi_pkg::Z_W-1:0]     impedance,
	output logic [1:0]                        status
);

	localparam int D = mi_pkg::DEPTH;

	logic adv;
	logic [D:1] vld_q;

	assign adv       = !vld_q[D] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[D-1:1], in_valid};
		end
	end

	function automatic logic [mi_pkg::K_W-1:0] msb_idx(input logic [mi_pkg::NUM_W-1:0] x);
		logic [mi_pkg::K_W-1:0] k;
		k = '0;
		for (int i = 0; i < mi_pkg::NUM_W; i++) begin
			if (x[i]) k = mi_pkg::K_W'(i);
		end
		return k;
	endfunction

	function automatic logic [mi_pkg::MANT_W-1:0] norm(input logic [mi_pkg::NUM_W-1:0] x,
			input logic [mi_pkg::K_W-1:0] k);
		logic [mi_pkg::NUM_W-1:0] y;
		if (k >= mi_pkg::K_W'(30)) y = x >> (k - mi_pkg::K_W'(30));
		else y = x << (mi_pkg::K_W'(30) - k);
		return y[mi_pkg::MANT_W-1:0];
	endfunction

	// front end
	mi_pkg::status_t code_s [1:D-1];
	logic [mi_pkg::NUM_W-1:0] num_s1, num_s2;
	logic [mi_pkg::DEN_W-1:0] den_s1, den_s2;
	logic [mi_pkg::K_W-1:0] kn_s2, kd_s2;

	// log2 squaring chain, index 0 is the normalize stage
	logic [mi_pkg::MANT_W-1:0] mn_s [0:mi_pkg::FRAC_W];
	logic [mi_pkg::MANT_W-1:0] md_s [0:mi_pkg::FRAC_W];
	logic [mi_pkg::FRAC_W-1:0] fn_s [0:mi_pkg::FRAC_W];
	logic [mi_pkg::FRAC_W-1:0] fd_s [0:mi_pkg::FRAC_W];
	logic [mi_pkg::K_W-1:0] kn_s [0:mi_pkg::FRAC_W];
	logic [mi_pkg::K_W-1:0] kd_s [0:mi_pkg::FRAC_W];

	logic lg_neg_s28;
	logic [mi_pkg::LG_W-1:0] lg_mag_s28;
	logic ln_neg_s [mi_pkg::ST_LN:mi_pkg::ST_COEF];
	logic [mi_pkg::LN_W-1:0] ln_mag_s [mi_pkg::ST_LN:mi_pkg::ST_COEF];

	// sqrt chain
	logic [mi_pkg::SQV_W-1:0] sq_v_s [1:mi_pkg::ST_SQRT];
	logic [mi_pkg::SQR_W-1:0] sq_r_s [1:mi_pkg::ST_SQRT];

	// divider chain
	logic [mi_pkg::REM_W-1:0]  dv_rem_s [mi_pkg::ST_DIV0:mi_pkg::ST_COEF];
	logic [mi_pkg::ROOT_W-1:0] dv_r_s   [mi_pkg::ST_DIV0:mi_pkg::ST_COEF];
	logic [mi_pkg::QUO_W-1:0]  dv_q_s   [mi_pkg::ST_DIV0:mi_pkg::ST_COEF];

	logic z_neg_s49;
	logic [mi_pkg::ZM_W-1:0] z_mag_s49;
	logic signed [mi_pkg::Z_W-1:0] imp_s50;
	mi_pkg::status_t sts_s50;

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			num_s1 <= mi_pkg::NUM_W'(mi_pkg::H_SCALE) * mi_pkg::NUM_W'(height);
			den_s1 <= mi_pkg::DEN_W'(mi_pkg::W_SCALE) * mi_pkg::DEN_W'(width)
				+ mi_pkg::DEN_W'(mi_pkg::T_SCALE) * mi_pkg::DEN_W'(thickness);
			if (width == '0 && thickness == '0) code_s[1] <= mi_pkg::ST_ZERO_DEN;
			else if (height == '0) code_s[1] <= mi_pkg::ST_BAD_LOG;
			else code_s[1] <= mi_pkg::ST_OK;
			for (int i = 2; i < D; i++) code_s[i] <= code_s[i-1];

			sq_v_s[1] <= mi_pkg::SQV_W'(17'(permittivity) + mi_pkg::ER_OFFSET) << 28;
			sq_r_s[1] <= '0;

			// stage 2
			num_s2 <= num_s1;
			den_s2 <= den_s1;
			kn_s2  <= msb_idx(num_s1);
			kd_s2  <= msb_idx(mi_pkg::NUM_W'(den_s1));

			// stage 3
			mn_s[0] <= norm(num_s2, kn_s2);
			md_s[0] <= norm(mi_pkg::NUM_W'(den_s2), kd_s2);
			fn_s[0] <= '0;
			fd_s[0] <= '0;
			kn_s[0] <= kn_s2;
			kd_s[0] <= kd_s2;

			for (int j = 0; j < mi_pkg::FRAC_W; j++) begin
				logic [2*mi_pkg::MANT_W-1:0] pn, pd;
				pn = 62'(mn_s[j]) * 62'(mn_s[j]);
				pd = 62'(md_s[j]) * 62'(md_s[j]);
				mn_s[j+1] <= pn[61] ? pn[61:31] : pn[60:30];
				md_s[j+1] <= pd[61] ? pd[61:31] : pd[60:30];
				fn_s[j+1] <= {fn_s[j][mi_pkg::FRAC_W-2:0], pn[61]};
				fd_s[j+1] <= {fd_s[j][mi_pkg::FRAC_W-2:0], pd[61]};
				kn_s[j+1] <= kn_s[j];
				kd_s[j+1] <= kd_s[j];
			end

			// stage 28: log difference as sign and magnitude
			begin
				logic [mi_pkg::LG_W-1:0] a, b;
				a = {kn_s[mi_pkg::FRAC_W], fn_s[mi_pkg::FRAC_W]};
				b = {kd_s[mi_pkg::FRAC_W], fd_s[mi_pkg::FRAC_W]};
				lg_neg_s28 <= a < b;
				lg_mag_s28 <= (a < b) ? b - a : a - b;
			end

			// stage 29: natural log
			begin
				logic [2*mi_pkg::LN_W-1:0] p;
				p = 60'(lg_mag_s28) * 60'(mi_pkg::LN2_Q30) + (60'(1) << 29);
				ln_mag_s[mi_pkg::ST_LN] <= p[59:30];
				ln_neg_s[mi_pkg::ST_LN] <= lg_neg_s28;
			end
			for (int i = mi_pkg::ST_LN + 1; i <= mi_pkg::ST_COEF; i++) begin
				ln_mag_s[i] <= ln_mag_s[i-1];
				ln_neg_s[i] <= ln_neg_s[i-1];
			end

			// sqrt, one result bit per stage
			for (int i = 0; i < mi_pkg::ROOT_W; i++) begin
				logic [mi_pkg::SQR_W:0] sum;
				logic [mi_pkg::SQR_W-1:0] bt;
				bt  = mi_pkg::SQR_W'(1) << (44 - 2 * i);
				sum = 47'(sq_r_s[i+1]) + 47'(bt);
				if (47'(sq_v_s[i+1]) >= sum) begin
					sq_v_s[i+2] <= sq_v_s[i+1] - sum[mi_pkg::SQV_W-1:0];
					sq_r_s[i+2] <= (sq_r_s[i+1] >> 1) + bt;
				end else begin
					sq_v_s[i+2] <= sq_v_s[i+1];
					sq_r_s[i+2] <= sq_r_s[i+1] >> 1;
				end
			end

			// divider setup
			dv_rem_s[mi_pkg::ST_DIV0] <= mi_pkg::COEF_NUM
				+ mi_pkg::REM_W'(sq_r_s[mi_pkg::ST_SQRT][mi_pkg::ROOT_W-1:1]);
			dv_r_s[mi_pkg::ST_DIV0] <= sq_r_s[mi_pkg::ST_SQRT][mi_pkg::ROOT_W-1:0];
			dv_q_s[mi_pkg::ST_DIV0] <= '0;

			// restoring divide, one quotient bit per stage
			for (int j = 0; j < mi_pkg::QUO_W; j++) begin
				logic [mi_pkg::SQR_W-1:0] dsh;
				dsh = mi_pkg::SQR_W'(dv_r_s[mi_pkg::ST_DIV0+j]) << (mi_pkg::QUO_W - 1 - j);
				if (mi_pkg::SQR_W'(dv_rem_s[mi_pkg::ST_DIV0+j]) >= dsh) begin
					dv_rem_s[mi_pkg::ST_DIV0+j+1] <= dv_rem_s[mi_pkg::ST_DIV0+j]
						- dsh[mi_pkg::REM_W-1:0];
					dv_q_s[mi_pkg::ST_DIV0+j+1] <= dv_q_s[mi_pkg::ST_DIV0+j]
						| (mi_pkg::QUO_W'(1) << (mi_pkg::QUO_W - 1 - j));
				end else begin
					dv_rem_s[mi_pkg::ST_DIV0+j+1] <= dv_rem_s[mi_pkg::ST_DIV0+j];
					dv_q_s[mi_pkg::ST_DIV0+j+1] <= dv_q_s[mi_pkg::ST_DIV0+j];
				end
				dv_r_s[mi_pkg::ST_DIV0+j+1] <= dv_r_s[mi_pkg::ST_DIV0+j];
			end

			// stage 49: scale by coefficient
			begin
				logic [53:0] p;
				p = 54'(ln_mag_s[mi_pkg::ST_COEF]) * 54'(dv_q_s[mi_pkg::ST_COEF])
					+ (54'(1) << 31);
				z_mag_s49 <= p[32+mi_pkg::ZM_W-1:32];
				z_neg_s49 <= ln_neg_s[mi_pkg::ST_COEF];
			end

			// stage 50: special cases and saturation
			if (code_s[D-1] != mi_pkg::ST_OK) begin
				imp_s50 <= '0;
				sts_s50 <= code_s[D-1];
			end else if (z_neg_s49) begin
				if (z_mag_s49 > mi_pkg::Z_NEG_LIM) begin
					imp_s50 <= mi_pkg::Z_MIN;
					sts_s50 <= mi_pkg::ST_SAT;
				end else begin
					imp_s50 <= mi_pkg::Z_W'(-z_mag_s49);
					sts_s50 <= mi_pkg::ST_OK;
				end
			end else begin
				if (z_mag_s49 > mi_pkg::Z_POS_LIM) begin
					imp_s50 <= mi_pkg::Z_MAX;
					sts_s50 <= mi_pkg::ST_SAT;
				end else begin
					imp_s50 <= mi_pkg::Z_W'(z_mag_s49);
					sts_s50 <= mi_pkg::ST_OK;
				end
			end
		end
	end

	assign impedance = imp_s50;
	assign status    = sts_s50;

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mi_pkg::ST_SAT |-> impedance == mi_pkg::Z_MAX
			|| impedance == mi_pkg::Z_MIN)
		else $error("saturated word not at a bound");

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mi_pkg::ST_ZERO_DEN || status == mi_pkg::ST_BAD_LOG)
			|-> impedance == '0)
		else $error("special case word has nonzero impedance");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[mi_pkg::ST_COEF] |-> dv_rem_s[mi_pkg::ST_COEF]
			< mi_pkg::REM_W'(dv_r_s[mi_pkg::ST_COEF]))
		else $error("divider remainder not below divisor");

	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[mi_pkg::ST_NORM] && code_s[mi_pkg::ST_NORM] == mi_pkg::ST_OK
			|-> mn_s[0][mi_pkg::MANT_W-1] && md_s[0][mi_pkg::MANT_W-1])
		else $error("log mantissa not normalized");

endmodule

// ===== test/tb_microstrip_impedance_unit.sv =====
`timescale 1ns / 1ps

module tb_microstrip_impedance_unit;

	typedef struct {
		logic [mi_pkg::LEN_W-1:0] h;
		logic [mi_pkg::LEN_W-1:0] w;
		logic [mi_pkg::LEN_W-1:0] t;
		logic [mi_pkg::ER_W-1:0]  er;
	} geom_t;

	typedef struct {
		logic signed [mi_pkg::Z_W-1:0] z;
		mi_pkg::status_t               st;
	} zres_t;

	localparam longint CYCLE_LIMIT = 400000;
	localparam int     DRAIN_CYCLES = mi_pkg::DEPTH + 20;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [mi_pkg::LEN_W-1:0] height;
	logic [mi_pkg::LEN_W-1:0] width;
	logic [mi_pkg::LEN_W-1:0] thickness;
	logic [mi_pkg::ER_W-1:0]  permittivity;
	logic out_valid;
	logic out_ready;
	logic signed [mi_pkg::Z_W-1:0] impedance;
	logic [1:0] status;

	geom_t  pending_geom[$];
	zres_t  expected_z[$];
	int     errors;
	longint cycles;
	int     send_gap;
	int     recv_gap;

	microstrip_impedance_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.height(height), .width(width), .thickness(thickness),
		.permittivity(permittivity),
		.out_valid(out_valid), .out_ready(out_ready),
		.impedance(impedance), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] log2_fix24(logic [63:0] x);
		int k;
		logic [63:0] m;
		logic [63:0] frac;
		k = 63;
		frac = 0;
		while (x[k] == 1'b0)
			k--;
		if (k >= 30)
			m = x >> (k - 30);
		else
			m = x << (30 - k);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m[31]) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(k) << 24) | frac;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint scale_round(longint a, logic [63:0] b, int sh);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		q = (mag * b + (64'd1 << (sh - 1))) >> sh;
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic zres_t predict_impedance(geom_t g);
		zres_t r;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] root;
		logic [63:0] coef;
		longint lg;
		longint ln;
		longint z;
		num = 64'd598 * g.h;
		den = 64'd80 * g.w + 64'd100 * g.t;
		r.z = '0;
		r.st = mi_pkg::ST_OK;
		if (den == 0) begin
			r.st = mi_pkg::ST_ZERO_DEN;
			return r;
		end
		if (num == 0) begin
			r.st = mi_pkg::ST_BAD_LOG;
			return r;
		end
		lg = longint'(log2_fix24(num)) - longint'(log2_fix24(den));
		ln = scale_round(lg, 64'd744261118, 30);
		root = int_sqrt((64'(g.er) + 64'd5775) << 28);
		coef = ((64'd87 << 36) + (root >> 1)) / root;
		z = scale_round(ln, coef, 32);
		if (z > 524287) begin
			z = 524287;
			r.st = mi_pkg::ST_SAT;
		end else if (z < -524288) begin
			z = -524288;
			r.st = mi_pkg::ST_SAT;
		end
		r.z = mi_pkg::Z_W'(z);
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 45)
			return 0;
		if (p < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [mi_pkg::LEN_W-1:0] rand_len();
		int p;
		p = $urandom_range(9);
		if (p < 6)
			return mi_pkg::LEN_W'($urandom_range(4000, 1));
		if (p < 8)
			return mi_pkg::LEN_W'($urandom);
		if (p == 8)
			return '0;
		return mi_pkg::LEN_W'($urandom_range(16777215, 16777000));
	endfunction

	task automatic add_geom(logic [mi_pkg::LEN_W-1:0] h, logic [mi_pkg::LEN_W-1:0] w,
			logic [mi_pkg::LEN_W-1:0] t, logic [mi_pkg::ER_W-1:0] er);
		geom_t g;
		g.h = h;
		g.w = w;
		g.t = t;
		g.er = er;
		pending_geom.push_back(g);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			height <= '0;
			width <= '0;
			thickness <= '0;
			permittivity <= '0;
			send_gap <= 0;
		end else begin
			if (!in_valid || in_ready) begin
				if (in_valid && in_ready)
					expected_z.push_back(predict_impedance('{height, width,
						thickness, permittivity}));
				if (send_gap == 0 && pending_geom.size() > 0) begin
					geom_t g;
					g = pending_geom.pop_front();
					in_valid <= 1'b1;
					height <= g.h;
					width <= g.w;
					thickness <= g.t;
					permittivity <= g.er;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_z.size() == 0) begin
					$display("%0t: unexpected word z=%0d st=%0d", $time,
						impedance, status);
					errors++;
				end else begin
					zres_t e;
					e = expected_z.pop_front();
					if (impedance !== e.z) begin
						$display("%0t: impedance expected %0d actual %0d", $time,
							e.z, impedance);
						errors++;
					end
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time,
							e.st, status);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(3) == 0)
					recv_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		// directed
		add_geom(24'd0, 24'd0, 24'd0, 16'd0);
		add_geom(24'd100, 24'd0, 24'd0, 16'd17612);
		add_geom(24'd0, 24'd256, 24'd0, 16'd17612);
		add_geom(24'd0, 24'd0, 24'd256, 16'd17612);
		add_geom(24'd1280, 24'd1024, 24'd90, 16'd17612);
		add_geom(24'hFFFFFF, 24'd0, 24'd1, 16'd0);
		add_geom(24'hFFFFFF, 24'd1, 24'd0, 16'hFFFF);
		add_geom(24'd1, 24'hFFFFFF, 24'hFFFFFF, 16'd0);
		add_geom(24'd1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		add_geom(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h8000);
		add_geom(24'd1, 24'd1, 24'd1, 16'h1000);
		add_geom(24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555);
		add_geom(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA);
		add_geom(24'd300, 24'd225, 24'd0, 16'd4096);
		add_geom(24'd2, 24'd0, 24'd1, 16'd1);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 450; i++)
			add_geom(rand_len(), rand_len(), rand_len(), mi_pkg::ER_W'($urandom));
		wait (pending_geom.size() == 0 && !in_valid);
		wait (expected_z.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
src/mi_pkg.sv
src/microstrip_impedance_unit.sv
test/tb_microstrip_impedance_unit.sv
